/* rtl/rme_pkg.sv */
// shared types, opcodes and decode helpers for the register machine executor
package rme_pkg;

  localparam int unsigned OUT_REGS  = 6;
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned IDX_FLD_W = 3;
  localparam int unsigned PLEN_W    = 16;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } opcode_t;

  // register index on the configuration port
  typedef enum logic [0:0] {
    CFG_IP_REGISTER    = 1'b0,
    CFG_PROGRAM_LENGTH = 1'b1
  } cfg_reg_t;

  // which operands name a register
  typedef struct packed {
    logic a_reg;
    logic b_reg;
  } opdec_t;

  // per-instruction flags from the execute stage
  typedef struct packed {
    logic halted;
    logic bad_index;
  } status_t;

  function automatic opdec_t decode(opcode_t op);
    opdec_t d;
    d.a_reg = 1'b1;
    d.b_reg = 1'b0;
    unique case (op) inside
      OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: d.b_reg = 1'b1;
      OP_SETI:                                              d.a_reg = 1'b0;
      OP_GTIR, OP_EQIR: begin
        d.a_reg = 1'b0;
        d.b_reg = 1'b1;
      end
      default: d.b_reg = 1'b0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/rme_instr_if.sv */
// instruction channel: valid/ready handshake with one instruction per beat
interface rme_instr_if;
  logic                                  valid;
  logic                                  ready;
  logic [rme_pkg::OP_W-1:0]              action;
  logic signed [rme_pkg::FIELD_W-1:0]    operand_a;
  logic signed [rme_pkg::FIELD_W-1:0]    operand_b;
  logic [rme_pkg::IDX_FLD_W-1:0]         dest_index;

  modport source (output valid, action, operand_a, operand_b, dest_index, input ready);
  modport sink   (input valid, action, operand_a, operand_b, dest_index, output ready);
endinterface

/* rtl/rme_result_if.sv */
// result channel: register snapshot, pointer and flags per beat
interface rme_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [rme_pkg::FIELD_W-1:0] reg_zero;
  logic signed [rme_pkg::FIELD_W-1:0] reg_one;
  logic signed [rme_pkg::FIELD_W-1:0] reg_two;
  logic signed [rme_pkg::FIELD_W-1:0] reg_three;
  logic signed [rme_pkg::FIELD_W-1:0] reg_four;
  logic signed [rme_pkg::FIELD_W-1:0] reg_five;
  logic signed [rme_pkg::FIELD_W-1:0] next_pointer;
  logic                               halted;
  logic                               bad_index;

  modport source (output valid, reg_zero, reg_one, reg_two, reg_three, reg_four, reg_five,
                  next_pointer, halted, bad_index, input ready);
  modport sink   (input valid, reg_zero, reg_one, reg_two, reg_three, reg_four, reg_five,
                  next_pointer, halted, bad_index, output ready);
endinterface

/* rtl/rme_exec.sv */
// execute stage: alu, register file write-back, pointer increment and halt check
module rme_exec #(
  parameter int unsigned DATA_WIDTH     = 32,
  parameter int unsigned REGISTER_COUNT = 6
) (
  input  logic                                 fire,
  input  rme_pkg::opcode_t                     op,
  input  logic [DATA_WIDTH-1:0]                opa,
  input  logic [DATA_WIDTH-1:0]                opb,
  input  logic [rme_pkg::IDX_FLD_W-1:0]        dest_index,
  input  logic                                 src_bad,
  input  logic [DATA_WIDTH-1:0]                regs [REGISTER_COUNT],
  input  logic [rme_pkg::IDX_FLD_W-1:0]        ip_register,
  input  logic [rme_pkg::PLEN_W-1:0]           program_length,
  output logic [DATA_WIDTH-1:0]                regs_next [REGISTER_COUNT],
  output logic [DATA_WIDTH-1:0]                pointer,
  output rme_pkg::status_t                     status
);

  localparam int unsigned IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  logic [DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] alu_out;
  logic [DATA_WIDTH-1:0] pre [REGISTER_COUNT];
  logic                  dest_ok;
  logic                  ip_ok;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] ip_base;

  assign prod = opa * opb;

  always_comb begin
    case (op) inside
      rme_pkg::OP_ADDR, rme_pkg::OP_ADDI: alu_out = opa + opb;
      rme_pkg::OP_MULR, rme_pkg::OP_MULI: alu_out = prod;
      rme_pkg::OP_BANR, rme_pkg::OP_BANI: alu_out = opa & opb;
      rme_pkg::OP_BORR, rme_pkg::OP_BORI: alu_out = opa | opb;
      rme_pkg::OP_SETR, rme_pkg::OP_SETI: alu_out = opa;
      rme_pkg::OP_GTIR, rme_pkg::OP_GTRI, rme_pkg::OP_GTRR:
        alu_out = DATA_WIDTH'($signed(opa) > $signed(opb));
      default: alu_out = DATA_WIDTH'(opa == opb);
    endcase
  end

  assign dest_ok = {1'b0, dest_index} < (rme_pkg::IDX_FLD_W + 1)'(REGISTER_COUNT);
  assign ip_ok   = {1'b0, ip_register} < (rme_pkg::IDX_FLD_W + 1)'(REGISTER_COUNT);
  assign wr_en   = fire && dest_ok && !src_bad;

  // the instruction writes first, the increment lands on the written value
  always_comb begin
    for (int k = 0; k < REGISTER_COUNT; k++) begin
      pre[k] = (wr_en && dest_index == rme_pkg::IDX_FLD_W'(k)) ? alu_out : regs[k];
      regs_next[k] = (fire && ip_ok && ip_register == rme_pkg::IDX_FLD_W'(k)) ?
                     pre[k] + DATA_WIDTH'(1) : pre[k];
    end
  end

  assign ip_base = ip_ok ? pre[ip_register[IDX_W-1:0]] : '0;
  assign pointer = ip_ok ? ip_base + DATA_WIDTH'(1) : '0;

  assign status.bad_index = src_bad || !dest_ok;
  assign status.halted    = !ip_ok || pointer[DATA_WIDTH-1] ||
                            (pointer >= DATA_WIDTH'(program_length));

endmodule

/* rtl/register_machine_executor_unit.sv */
// top level of the register machine executor: operand read, execute and result stages
//
// One instruction is accepted per beat and the block sustains one instruction
// per clock while results are taken; an untaken result stalls the operand
// register and input. An accepted instruction sits in the operand register
// (register reads taken from the register file's next value, so the previous
// instruction's write-back is seen), which drives the execute stage directly;
// its alu result, pointer increment and halt check land in the register file
// and the result register when the execute stage fires. The write-back loop
// through the execute stage sets the rate of one instruction per cycle.
// Configuration is read and written over apb: ip_register at 0, program_length at 4.
module register_machine_executor_unit #(
  parameter int unsigned DATA_WIDTH     = 32,
  parameter int unsigned REGISTER_COUNT = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  rme_instr_if.sink                      instr,
  rme_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rme_pkg::PADDR_W-1:0]    paddr,
  input  logic [rme_pkg::PDATA_W-1:0]    pwdata,
  output logic [rme_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int unsigned IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  // configuration
  logic [rme_pkg::IDX_FLD_W-1:0] ip_register;
  logic [rme_pkg::PLEN_W-1:0]    program_length;
  rme_pkg::cfg_reg_t             cfg_sel;
  logic                          cfg_wr;

  // architectural register file
  logic [DATA_WIDTH-1:0] regs      [REGISTER_COUNT];
  logic [DATA_WIDTH-1:0] regs_next [REGISTER_COUNT];

  // operand stage
  logic                          s1_valid;
  rme_pkg::opcode_t              s1_op;
  logic [DATA_WIDTH-1:0]         s1_a;
  logic [DATA_WIDTH-1:0]         s1_b;
  logic [rme_pkg::IDX_FLD_W-1:0] s1_dest;
  logic                          s1_bad;

  // result stage
  logic                          out_valid;
  logic [rme_pkg::FIELD_W-1:0]   out_regs [rme_pkg::OUT_REGS];
  logic [rme_pkg::FIELD_W-1:0]   out_ptr;
  rme_pkg::status_t              out_status;

  logic                          in_fire;
  logic                          exec_fire;
  rme_pkg::opdec_t               dec;
  logic                          a_ok;
  logic                          b_ok;
  logic [DATA_WIDTH-1:0]         a_val;
  logic [DATA_WIDTH-1:0]         b_val;
  logic [DATA_WIDTH-1:0]         ex_ptr;
  rme_pkg::status_t              ex_status;
  logic [rme_pkg::FIELD_W-1:0]   view [rme_pkg::OUT_REGS];

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = rme_pkg::cfg_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_sel)
      rme_pkg::CFG_IP_REGISTER:    prdata = rme_pkg::PDATA_W'(ip_register);
      rme_pkg::CFG_PROGRAM_LENGTH: prdata = rme_pkg::PDATA_W'(program_length);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip_register    <= '0;
      program_length <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        rme_pkg::CFG_IP_REGISTER:    ip_register    <= pwdata[rme_pkg::IDX_FLD_W-1:0];
        rme_pkg::CFG_PROGRAM_LENGTH: program_length <= pwdata[rme_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign exec_fire   = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || exec_fire;
  assign in_fire     = instr.valid && instr.ready;

  // ---------------- operand read ----------------
  assign dec  = rme_pkg::decode(rme_pkg::opcode_t'(instr.action));
  assign a_ok = $unsigned(instr.operand_a) < rme_pkg::FIELD_W'(REGISTER_COUNT);
  assign b_ok = $unsigned(instr.operand_b) < rme_pkg::FIELD_W'(REGISTER_COUNT);

  // reads see the write-back of the instruction executing this cycle
  always_comb begin
    if (dec.a_reg) begin
      a_val = a_ok ? regs_next[instr.operand_a[IDX_W-1:0]] : '0;
    end else begin
      a_val = DATA_WIDTH'(instr.operand_a);
    end
    if (dec.b_reg) begin
      b_val = b_ok ? regs_next[instr.operand_b[IDX_W-1:0]] : '0;
    end else begin
      b_val = DATA_WIDTH'(instr.operand_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op   <= rme_pkg::opcode_t'(instr.action);
      s1_a    <= a_val;
      s1_b    <= b_val;
      s1_dest <= instr.dest_index;
      s1_bad  <= (dec.a_reg && !a_ok) || (dec.b_reg && !b_ok);
    end
  end

  // ---------------- execute ----------------
  rme_exec #(
    .DATA_WIDTH     (DATA_WIDTH),
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_exec (
    .fire           (exec_fire),
    .op             (s1_op),
    .opa            (s1_a),
    .opb            (s1_b),
    .dest_index     (s1_dest),
    .src_bad        (s1_bad),
    .regs           (regs),
    .ip_register    (ip_register),
    .program_length (program_length),
    .regs_next      (regs_next),
    .pointer        (ex_ptr),
    .status         (ex_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REGISTER_COUNT; k++) begin
        regs[k] <= '0;
      end
    end else begin
      for (int k = 0; k < REGISTER_COUNT; k++) begin
        regs[k] <= regs_next[k];
      end
    end
  end

  // low 32 bits of each register, zero for registers that do not exist
  for (genvar k = 0; k < rme_pkg::OUT_REGS; k++) begin : g_view
    if (k < REGISTER_COUNT) begin : g_have
      assign view[k] = rme_pkg::FIELD_W'(regs_next[k]);
    end else begin : g_none
      assign view[k] = '0;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      for (int k = 0; k < rme_pkg::OUT_REGS; k++) begin
        out_regs[k] <= view[k];
      end
      out_ptr    <= rme_pkg::FIELD_W'(ex_ptr);
      out_status <= ex_status;
    end
  end

  assign result.valid        = out_valid;
  assign result.reg_zero     = out_regs[0];
  assign result.reg_one      = out_regs[1];
  assign result.reg_two      = out_regs[2];
  assign result.reg_three    = out_regs[3];
  assign result.reg_four     = out_regs[4];
  assign result.reg_five     = out_regs[5];
  assign result.next_pointer = out_ptr;
  assign result.halted       = out_status.halted;
  assign result.bad_index    = out_status.bad_index;

  // ---------------- assertions ----------------
  a_exec_to_result: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> result.valid)
    else $error("executed instruction produced no result");

  a_bad_ip: assert property (@(posedge clk) disable iff (rst)
    exec_fire && ({1'b0, ip_register} >= (rme_pkg::IDX_FLD_W + 1)'(REGISTER_COUNT))
    |=> result.halted && result.next_pointer == '0)
    else $error("missing pointer register must halt with zero pointer");

  a_bad_no_write: assert property (@(posedge clk) disable iff (rst)
    exec_fire && ex_status.bad_index && ip_register != '0
    |=> regs[0] == $past(regs[0]))
    else $error("register written despite bad index");

  a_run_ptr_sign: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.halted |-> !result.next_pointer[DATA_WIDTH > 32 ? 31 :
                                                             DATA_WIDTH - 1])
    else $error("running with a negative pointer");

endmodule
